// ----- src/rmq2d_pkg.sv -----
// ----------------------------------------------------------------------------
// rmq2d_pkg: shared types and codes for the 2-D range minimum query core
// Holds grid limits, action codes, status codes and register indexes.
// ----------------------------------------------------------------------------
package rmq2d_pkg;

   localparam int MAX_ROWS   = 32;
   localparam int MAX_COLS   = 32;
   localparam int VALUE_BITS = 32;

   localparam logic [1:0] ACT_WRITE    = 2'd0;
   localparam logic [1:0] ACT_BUILD    = 2'd1;
   localparam logic [1:0] ACT_QUERY    = 2'd2;
   localparam logic [1:0] ACT_RESERVED = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD      = 2'd1;
   localparam logic [1:0] ST_NO_BUILD = 2'd2;

   localparam logic [0:0] REG_ROWS = 1'd0;
   localparam logic [0:0] REG_COLS = 1'd1;

   typedef struct packed {
      logic [1:0]  action;
      logic [4:0]  row;
      logic [4:0]  col;
      logic [4:0]  row_end;
      logic [4:0]  col_end;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [31:0] minimum;
      logic [1:0]  status;
   } rsp_type;

endpackage

// ----- src/rmq2d_if.sv -----
// ----------------------------------------------------------------------------
// rmq2d_if: valid/ready channel
// Carries one payload of a configurable type with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rmq2d_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- src/rmq2d_ram.sv -----
// ----------------------------------------------------------------------------
// rmq2d_ram: generic single-port RAM
// One read or write per cycle, read data registered.
// ----------------------------------------------------------------------------
module rmq2d_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

// ----- src/range_min_query_2d_core.sv -----
// ----------------------------------------------------------------------------
// range_min_query_2d_core: 2-D sparse table range minimum query
// Stores a signed grid, builds all power-of-two levels, answers rectangle
// minima from four overlapping entries.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  req      | in  | req.valid/ready    | action,row,col,row_end,col_end,value
//  rsp      | out | rsp.valid/ready    | minimum,status
//  csr      | in  | APB psel/penable   | rows_in_use, cols_in_use
//
// A write is done and answered from the idle state; a query steps through
// four reads through the single RAM port and the last compare; a build
// works each table entry of every level in the steps read, read, write,
// advance, over the positions that fit the level. One request is worked
// at a time; a request is taken only while the result register is empty.
// Synchronous active-high reset clears the control state and built_ff and
// sets rows and cols to their maximum; the table memory holds garbage
// until written. The result holds while rsp.ready is low.
module range_min_query_2d_core (
   input  logic        clock,
   input  logic        reset,
   rmq2d_if.sink       req,
   rmq2d_if.source     rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rmq2d_pkg::*;

   localparam int RB = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CB = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RL = $clog2(MAX_ROWS) + 1;
   localparam int CL = $clog2(MAX_COLS) + 1;
   localparam int AB = (RL > 1) ? $clog2(RL) : 1;
   localparam int BB = (CL > 1) ? $clog2(CL) : 1;
   localparam int DEPTH = RL * CL * MAX_ROWS * MAX_COLS;
   localparam int DB = $clog2(DEPTH);
   localparam int NB = $clog2(MAX_ROWS + 1) > $clog2(MAX_COLS + 1) ?
                       $clog2(MAX_ROWS + 1) : $clog2(MAX_COLS + 1);
   localparam logic [NB-1:0] MAXR = NB'(MAX_ROWS);
   localparam logic [NB-1:0] MAXC = NB'(MAX_COLS);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_WR    = 4'd1;
   localparam logic [3:0] S_BRD0  = 4'd2;
   localparam logic [3:0] S_BRD1  = 4'd3;
   localparam logic [3:0] S_BWR   = 4'd4;
   localparam logic [3:0] S_BNEXT = 4'd5;
   localparam logic [3:0] S_QRD   = 4'd6;
   localparam logic [3:0] S_QLAST = 4'd7;

   logic [3:0]            state_ff, state_in;
   logic [NB-1:0]         rows_ff, rows_in, cols_ff, cols_in;
   logic                  built_ff, built_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic [AB-1:0]         a_ff, a_in;
   logic [BB-1:0]         b_ff, b_in;
   logic [RB-1:0]         i_ff, i_in, r0_ff, r0_in, r2_ff, r2_in;
   logic [CB-1:0]         j_ff, j_in, c0_ff, c0_in, c2_ff, c2_in;
   logic [1:0]            q_ff, q_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [AB-1:0]         la;
   logic [BB-1:0]         lb;

   logic                  ram_we;
   logic [DB-1:0]         ram_addr;
   logic [VALUE_BITS-1:0] ram_wdata, ram_rdata;

   rmq2d_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .we(ram_we), .addr(ram_addr),
      .wdata(ram_wdata), .rdata(ram_rdata)
   );

   function automatic logic [DB-1:0] slot(logic [AB-1:0] a, logic [BB-1:0] b,
                                         logic [RB-1:0] i, logic [CB-1:0] j);
      logic [DB+12:0] s;
      s = ((((DB+13)'(a) * (DB+13)'(CL) + (DB+13)'(b)) * (DB+13)'(MAX_ROWS)
           + (DB+13)'(i)) * (DB+13)'(MAX_COLS)) + (DB+13)'(j);
      return DB'(s);
   endfunction

   function automatic logic [4:0] flog2(logic [NB-1:0] n);
      logic [4:0] k;
      k = '0;
      for (int t = 0; t < NB; t++) begin
         if (n[t]) begin
            k = 5'(t);
         end
      end
      return k;
   endfunction

   function automatic logic [NB-1:0] clampv(logic [31:0] d, logic [NB-1:0] mx);
      logic [5:0] v;
      v = d[5:0];
      if (v == 6'd0) return NB'(1);
      if ({{32{1'b0}}, v} > 38'(mx)) return mx;
      return NB'(v);
   endfunction

   function automatic logic less(logic [VALUE_BITS-1:0] x, logic [VALUE_BITS-1:0] y);
      return $signed(x) < $signed(y);
   endfunction

   assign la = AB'(flog2(rows_ff));
   assign lb = BB'(flog2(cols_ff));

   // configuration
   logic csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   always_comb begin
      unique case (csr_paddr[2])
         REG_ROWS: csr_prdata = 32'(rows_ff);
         default:  csr_prdata = 32'(cols_ff);
      endcase
   end

   // request decode
   req_type rq;
   logic    take;
   assign rq = req.data;
   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign take = req.valid && req.ready;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   logic [NB-1:0] hgt, wid, qh, qw;
   logic [4:0]    qa, qb;
   logic          wr_ok, q_bad, last_j, last_i, last_b, last_a;
   logic [NB:0]   ip, jp;

   always_comb begin
      wr_ok = (NB'(rq.row) < rows_ff) && (NB'(rq.col) < cols_ff)
              && ({1'b0, rq.row} < 6'(MAX_ROWS)) && ({1'b0, rq.col} < 6'(MAX_COLS));
      q_bad = (rq.row > rq.row_end) || (rq.col > rq.col_end)
              || (NB'(rq.row_end) >= rows_ff) || (NB'(rq.col_end) >= cols_ff)
              || ({1'b0, rq.row_end} >= 6'(MAX_ROWS))
              || ({1'b0, rq.col_end} >= 6'(MAX_COLS));
      qh = NB'(rq.row_end) - NB'(rq.row) + NB'(1);
      qw = NB'(rq.col_end) - NB'(rq.col) + NB'(1);
      qa = flog2(qh);
      qb = flog2(qw);
      hgt = NB'(1) << a_ff;
      wid = NB'(1) << b_ff;
      ip = (NB+1)'(i_ff) + (NB+1)'(hgt) + (NB+1)'(1);
      jp = (NB+1)'(j_ff) + (NB+1)'(wid) + (NB+1)'(1);
      last_j = jp > (NB+1)'(cols_ff);
      last_i = ip > (NB+1)'(rows_ff);
      last_b = b_ff == lb;
      last_a = a_ff == la;
   end

   always_comb begin
      state_in = state_ff; rows_in = rows_ff; cols_in = cols_ff;
      built_in = built_ff; rsp_valid_in = rsp_valid_ff; rsp_in = rsp_ff;
      a_in = a_ff; b_in = b_ff; i_in = i_ff; j_in = j_ff;
      r0_in = r0_ff; c0_in = c0_ff; r2_in = r2_ff; c2_in = c2_ff;
      q_in = q_ff; acc_in = acc_ff;
      ram_we = 1'b0; ram_addr = '0; ram_wdata = rq.value[VALUE_BITS-1:0];

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_wr) begin
         // a register change invalidates the table
         built_in = 1'b0;
         unique case (csr_paddr[2])
            REG_ROWS: rows_in = clampv(csr_pwdata, MAXR);
            default:  cols_in = clampv(csr_pwdata, MAXC);
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               rsp_in = '{minimum: '0, status: ST_OK};
               priority if (rq.action == ACT_WRITE) begin
                  if (wr_ok) begin
                     ram_we   = 1'b1;
                     ram_addr = slot('0, '0, RB'(rq.row), CB'(rq.col));
                     built_in = 1'b0;
                  end else begin
                     rsp_in.status = ST_BAD;
                  end
                  rsp_valid_in = 1'b1;
               end else if (rq.action == ACT_BUILD) begin
                  // level (0,0) holds the grid; start at the next level
                  a_in = '0; b_in = BB'(1); i_in = '0; j_in = '0;
                  if (lb == '0) begin
                     a_in = AB'(1);
                     b_in = '0;
                  end
                  if (la == '0 && lb == '0) begin
                     built_in = 1'b1;
                     rsp_valid_in = 1'b1;
                  end else begin
                     state_in = S_BRD0;
                  end
               end else if (rq.action == ACT_QUERY) begin
                  if (!built_ff) begin
                     rsp_in.status = ST_NO_BUILD;
                     rsp_valid_in = 1'b1;
                  end else if (q_bad) begin
                     rsp_in.status = ST_BAD;
                     rsp_valid_in = 1'b1;
                  end else begin
                     a_in  = AB'(qa); b_in = BB'(qb);
                     r0_in = RB'(rq.row); c0_in = CB'(rq.col);
                     r2_in = RB'(NB'(rq.row_end) + NB'(1) - (NB'(1) << qa));
                     c2_in = CB'(NB'(rq.col_end) + NB'(1) - (NB'(1) << qb));
                     q_in  = 2'd0;
                     state_in = S_QRD;
                  end
               end else begin
                  rsp_in.status = ST_BAD;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_WR: state_in = S_IDLE;
         S_BRD0: begin
            ram_addr = (a_ff == '0) ? slot('0, b_ff - BB'(1), i_ff, j_ff)
                                    : slot(a_ff - AB'(1), b_ff, i_ff, j_ff);
            state_in = S_BRD1;
         end
         S_BRD1: begin
            ram_addr = (a_ff == '0)
               ? slot('0, b_ff - BB'(1), i_ff, j_ff + CB'(wid >> 1))
               : slot(a_ff - AB'(1), b_ff, i_ff + RB'(hgt >> 1), j_ff);
            acc_in = ram_rdata;
            state_in = S_BWR;
         end
         S_BWR: begin
            ram_we    = 1'b1;
            ram_addr  = slot(a_ff, b_ff, i_ff, j_ff);
            ram_wdata = less(ram_rdata, acc_ff) ? ram_rdata : acc_ff;
            state_in  = S_BNEXT;
         end
         S_BNEXT: begin
            // advance column, row, column level, row level
            state_in = S_BRD0;
            if (!last_j) begin
               j_in = j_ff + CB'(1);
            end else begin
               j_in = '0;
               if (!last_i) begin
                  i_in = i_ff + RB'(1);
               end else begin
                  i_in = '0;
                  if (!last_b) begin
                     b_in = b_ff + BB'(1);
                  end else begin
                     b_in = '0;
                     if (!last_a) begin
                        a_in = a_ff + AB'(1);
                     end else begin
                        built_in = 1'b1;
                        rsp_valid_in = 1'b1;
                        state_in = S_IDLE;
                     end
                  end
               end
            end
         end
         S_QRD: begin
            // issue corner reads; fold each returned entry into the minimum
            unique case (q_ff)
               2'd0: ram_addr = slot(a_ff, b_ff, r0_ff, c0_ff);
               2'd1: ram_addr = slot(a_ff, b_ff, r0_ff, c2_ff);
               2'd2: ram_addr = slot(a_ff, b_ff, r2_ff, c0_ff);
               default: ram_addr = slot(a_ff, b_ff, r2_ff, c2_ff);
            endcase
            if (q_ff == 2'd1) begin
               acc_in = ram_rdata;
            end else if (q_ff != 2'd0) begin
               acc_in = less(ram_rdata, acc_ff) ? ram_rdata : acc_ff;
            end
            q_in = q_ff + 2'd1;
            if (q_ff == 2'd3) begin
               state_in = S_QLAST;
            end
         end
         S_QLAST: begin
            rsp_in.minimum = 32'(less(ram_rdata, acc_ff) ? ram_rdata : acc_ff);
            rsp_in.status  = ST_OK;
            rsp_valid_in   = 1'b1;
            state_in       = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rows_ff      <= MAXR;
         cols_ff      <= MAXC;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         built_ff     <= built_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
      a_ff <= a_in; b_ff <= b_in; i_ff <= i_in; j_ff <= j_in;
      r0_ff <= r0_in; c0_ff <= c0_in; r2_ff <= r2_in; c2_ff <= c2_in;
      q_ff <= q_in; acc_ff <= acc_in;
   end

   a_busy_no_take: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req.ready) else $error("request taken while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("result dropped");
   a_query_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_QLAST) |=> (rsp_valid_ff && rsp_ff.status == ST_OK))
      else $error("query result missing");
   a_rows_range: assert property (@(posedge clock) disable iff (reset)
      (rows_ff != '0) && (rows_ff <= MAXR)) else $error("rows out of range");
endmodule
